/* sv/m3i_pkg.sv */
`default_nettype none
package m3i_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ELEM_W       = 32;
   localparam int LANES        = 9;
   localparam int DET_TERMS    = 3;
   localparam int THR_W        = 17;
   localparam int QUO_W        = 32;
   localparam int PROD_W       = 2 * ELEM_W;
   localparam int COF_W        = PROD_W;
   localparam int CMAG_W       = COF_W - 1;
   localparam int DET_W        = ELEM_W + COF_W + 1;
   localparam int ADET_W       = DET_W - 1;
   localparam int CSH          = 2 * FRAC_BITS + 1;
   localparam int THR_SH       = 2 * FRAC_BITS;
   localparam int NUM_W        = ((CMAG_W + CSH > ADET_W) ? CMAG_W + CSH : ADET_W) + 1;
   localparam int DEN_W        = ADET_W + 1;
   localparam int HI_W         = NUM_W - QUO_W;
   localparam int FRONT_STAGES = 6;
   localparam int DIV_STAGES   = QUO_W + 1;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic [CMAG_W-1:0]        cmag_type;
   typedef logic signed [DET_W-1:0]  det_type;
   typedef logic [ADET_W-1:0]        adet_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [DEN_W-1:0]         den_type;
   typedef logic [QUO_W-1:0]         quo_type;
   typedef logic [THR_W-1:0]         thr_type;

   typedef struct packed {
      den_type          den;
      logic [LANES-1:0] neg;
      logic             singular;
   } div_ctl_type;

   typedef struct packed {
      logic [LANES-1:0] neg;
      logic [LANES-1:0] ovf;
      logic             singular;
   } res_ctl_type;

   localparam thr_type THR_RESET = thr_type'(1);
   localparam quo_type SAT_POS   = {1'b0, {(QUO_W-1){1'b1}}};
   localparam quo_type SAT_NEG   = {1'b1, {(QUO_W-1){1'b0}}};

   // cofactor i = m[a]*m[b] - m[c]*m[d]
   localparam int COF_IDX [LANES][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

endpackage
`default_nettype wire

/* sv/m3i_front.sv */
`default_nettype none
module m3i_front import m3i_pkg::*; (
   input  wire logic                    clock,
   input  wire logic [FRONT_STAGES-1:0] en,
   input  wire elem_type                elem [LANES],
   input  wire thr_type                 thr,
   output num_type                      num [LANES],
   output div_ctl_type                  ctl
);

   prod_type         prod_ff [2*LANES];
   prod_type         prod_in [2*LANES];
   elem_type         ma_ff [DET_TERMS];
   elem_type         mb_ff [DET_TERMS];
   cof_type          cof_b_ff [LANES];
   cof_type          cof_b_in [LANES];
   cof_type          cof_c_ff [LANES];
   prod_type         ph_ff [DET_TERMS];
   prod_type         ph_in [DET_TERMS];
   prod_type         pl_ff [DET_TERMS];
   prod_type         pl_in [DET_TERMS];
   cof_type          cof_d_ff [LANES];
   det_type          det_ff;
   det_type          det_in;
   cmag_type         cmag_ff [LANES];
   cmag_type         cmag_in [LANES];
   logic [LANES-1:0] csign_ff;
   adet_type         adet_ff;
   adet_type         adet_in;
   logic             dneg_ff;
   num_type          num_ff [LANES];
   num_type          num_in [LANES];
   div_ctl_type      ctl_ff;
   div_ctl_type      ctl_in;

   // stage a: the eighteen 2x2 products
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod_in[2*i]   = elem[COF_IDX[i][0]] * elem[COF_IDX[i][1]];
         prod_in[2*i+1] = elem[COF_IDX[i][2]] * elem[COF_IDX[i][3]];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         for (int j = 0; j < DET_TERMS; j++) ma_ff[j] <= elem[j];
      end
   end

   // stage b: cofactors
   always_comb begin
      for (int i = 0; i < LANES; i++) cof_b_in[i] = prod_ff[2*i] - prod_ff[2*i+1];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cof_b_ff <= cof_b_in;
         mb_ff    <= ma_ff;
      end
   end

   // stage c: determinant terms split in two 32-bit halves of the cofactor
   always_comb begin
      for (int j = 0; j < DET_TERMS; j++) begin
         ph_in[j] = mb_ff[j] * $signed(cof_b_ff[j*DET_TERMS][COF_W-1:ELEM_W]);
         pl_in[j] = mb_ff[j] * $signed({1'b0, cof_b_ff[j*DET_TERMS][ELEM_W-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ph_ff    <= ph_in;
         pl_ff    <= pl_in;
         cof_c_ff <= cof_b_ff;
      end
   end

   // stage d: determinant sum
   always_comb begin
      det_in = '0;
      for (int j = 0; j < DET_TERMS; j++) begin
         det_in = det_in + (det_type'(ph_ff[j]) <<< ELEM_W) + det_type'(pl_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         det_ff   <= det_in;
         cof_d_ff <= cof_c_ff;
      end
   end

   // stage e: magnitudes and signs
   always_comb begin
      adet_in = adet_type'(det_ff[DET_W-1] ? -det_ff : det_ff);
      for (int i = 0; i < LANES; i++) begin
         cmag_in[i] = cmag_type'(cof_d_ff[i][COF_W-1] ? -cof_d_ff[i] : cof_d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         adet_ff <= adet_in;
         dneg_ff <= det_ff[DET_W-1];
         cmag_ff <= cmag_in;
         for (int i = 0; i < LANES; i++) csign_ff[i] <= cof_d_ff[i][COF_W-1];
      end
   end

   // stage f: rounded dividend, divisor and singular test
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         num_in[i] = (num_type'(cmag_ff[i]) << CSH) + num_type'(adet_ff);
      end
      ctl_in.den      = {adet_ff, 1'b0};
      ctl_in.neg      = csign_ff ^ {LANES{dneg_ff}};
      ctl_in.singular = (adet_ff == '0) || (adet_ff < (adet_type'(thr) << THR_SH));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         num_ff <= num_in;
         ctl_ff <= ctl_in;
      end
   end

   assign num = num_ff;
   assign ctl = ctl_ff;

endmodule
`default_nettype wire

/* sv/m3i_div.sv */
`default_nettype none
module m3i_div import m3i_pkg::*; (
   input  wire logic                  clock,
   input  wire logic [DIV_STAGES-1:0] en,
   input  wire num_type               num [LANES],
   input  wire div_ctl_type           ctl,
   output quo_type                    quo [LANES],
   output res_ctl_type                res
);

   den_type          rem_ff [DIV_STAGES][LANES];
   quo_type          sh_ff [DIV_STAGES][LANES];
   div_ctl_type      ctl_ff [DIV_STAGES];
   logic [LANES-1:0] ovf_ff [DIV_STAGES];
   den_type          rem0_in [LANES];
   logic [LANES-1:0] ovf_in;

   // quotient reaches 2^32 when the upper dividend part is not below the divisor
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rem0_in[l] = den_type'(num[l][NUM_W-1:QUO_W]);
         ovf_in[l]  = rem0_in[l] >= ctl.den;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= rem0_in;
         for (int l = 0; l < LANES; l++) sh_ff[0][l] <= num[l][QUO_W-1:0];
         ctl_ff[0] <= ctl;
         ovf_ff[0] <= ovf_in;
      end
   end

   // one quotient bit per stage; low dividend bits shift out as quotient bits shift in
   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
      always_ff @(posedge clock) begin
         if (en[s]) begin
            ctl_ff[s] <= ctl_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
      end
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         logic           ge;
         den_type        rem_in;
         quo_type        sh_in;

         assign trial  = {rem_ff[s-1][l], sh_ff[s-1][l][QUO_W-1]};
         assign diff   = trial - {1'b0, ctl_ff[s-1].den};
         assign ge     = trial >= {1'b0, ctl_ff[s-1].den};
         assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         assign sh_in  = {sh_ff[s-1][l][QUO_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (en[s]) begin
               rem_ff[s][l] <= rem_in;
               sh_ff[s][l]  <= sh_in;
            end
         end
      end
   end

   assign quo          = sh_ff[DIV_STAGES-1];
   assign res.neg      = ctl_ff[DIV_STAGES-1].neg;
   assign res.ovf      = ovf_ff[DIV_STAGES-1];
   assign res.singular = ctl_ff[DIV_STAGES-1].singular;

endmodule
`default_nettype wire

/* sv/matrix3_inverse.sv */
// 3x3 matrix inverse, signed Q16.16, by adjugate over determinant with each element rounded
// to nearest (ties away from zero) and saturated to 32 bits. A new matrix is taken every
// cycle while req_stall is low; each result passes through the 6 stages of products,
// cofactors, determinant, magnitudes and dividend, the 33 stages of the bit-per-stage
// restoring dividers (one per element, sharing the divisor) and the output register.
// Bubbles in the pipe close up under rsp_stall, so input beats keep flowing until every
// stage is full. When |det| is below csr_wr_data-programmed singular_threshold (reset 1),
// or det is zero, rsp_singular is set and all elements are zero. Write the threshold only
// while the pipe is empty.
`default_nettype none
module matrix3_inverse import m3i_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     csr_wr_en,
   input  wire thr_type  csr_wr_data,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire elem_type req_elem_0,
   input  wire elem_type req_elem_1,
   input  wire elem_type req_elem_2,
   input  wire elem_type req_elem_3,
   input  wire elem_type req_elem_4,
   input  wire elem_type req_elem_5,
   input  wire elem_type req_elem_6,
   input  wire elem_type req_elem_7,
   input  wire elem_type req_elem_8,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output elem_type      rsp_inv_0,
   output elem_type      rsp_inv_1,
   output elem_type      rsp_inv_2,
   output elem_type      rsp_inv_3,
   output elem_type      rsp_inv_4,
   output elem_type      rsp_inv_5,
   output elem_type      rsp_inv_6,
   output elem_type      rsp_inv_7,
   output elem_type      rsp_inv_8,
   output logic          rsp_singular
);

   localparam int LAST = PIPE_STAGES - 1;

   thr_type                thr_ff;
   logic [PIPE_STAGES-1:0] v_ff;
   logic [PIPE_STAGES-1:0] v_in;
   logic [PIPE_STAGES-1:0] en;
   elem_type               elem [LANES];
   num_type                num [LANES];
   div_ctl_type            div_ctl;
   quo_type                quo [LANES];
   res_ctl_type            res;
   elem_type               inv_ff [LANES];
   elem_type               inv_in [LANES];
   logic                   sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // a stage loads when it is empty or the stage after it loads
   always_comb begin
      en[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) en[k] = !v_ff[k] || en[k+1];
      v_in = {v_ff[LAST-1:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[LAST];

   assign elem[0] = req_elem_0;
   assign elem[1] = req_elem_1;
   assign elem[2] = req_elem_2;
   assign elem[3] = req_elem_3;
   assign elem[4] = req_elem_4;
   assign elem[5] = req_elem_5;
   assign elem[6] = req_elem_6;
   assign elem[7] = req_elem_7;
   assign elem[8] = req_elem_8;

   m3i_front u_front (
      .clock (clock),
      .en    (en[FRONT_STAGES-1:0]),
      .elem  (elem),
      .thr   (thr_ff),
      .num   (num),
      .ctl   (div_ctl)
   );

   m3i_div u_div (
      .clock (clock),
      .en    (en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
      .num   (num),
      .ctl   (div_ctl),
      .quo   (quo),
      .res   (res)
   );

   // sign and saturation
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (res.singular) begin
            inv_in[l] = '0;
         end else if (!res.neg[l]) begin
            inv_in[l] = (res.ovf[l] || quo[l][QUO_W-1]) ? SAT_POS : quo[l];
         end else if (res.ovf[l] || (quo[l][QUO_W-1] && (quo[l][QUO_W-2:0] != '0))) begin
            inv_in[l] = SAT_NEG;
         end else begin
            inv_in[l] = -quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         inv_ff  <= inv_in;
         sing_ff <= res.singular;
      end
   end

   assign rsp_inv_0    = inv_ff[0];
   assign rsp_inv_1    = inv_ff[1];
   assign rsp_inv_2    = inv_ff[2];
   assign rsp_inv_3    = inv_ff[3];
   assign rsp_inv_4    = inv_ff[4];
   assign rsp_inv_5    = inv_ff[5];
   assign rsp_inv_6    = inv_ff[6];
   assign rsp_inv_7    = inv_ff[7];
   assign rsp_inv_8    = inv_ff[8];
   assign rsp_singular = sing_ff;

endmodule
`default_nettype wire

/* sv/matrix3_inverse_checker.sv */
`default_nettype none
module matrix3_inverse_checker import m3i_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_stall,
   input wire logic     rsp_valid,
   input wire logic     rsp_stall,
   input wire elem_type rsp_inv_0,
   input wire elem_type rsp_inv_1,
   input wire elem_type rsp_inv_2,
   input wire elem_type rsp_inv_3,
   input wire elem_type rsp_inv_4,
   input wire elem_type rsp_inv_5,
   input wire elem_type rsp_inv_6,
   input wire elem_type rsp_inv_7,
   input wire elem_type rsp_inv_8,
   input wire logic     rsp_singular
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // input only backs up when the whole pipe is full and the output is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while output is free");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> ((rsp_inv_0 == '0) && (rsp_inv_1 == '0)
         && (rsp_inv_2 == '0) && (rsp_inv_3 == '0) && (rsp_inv_4 == '0)
         && (rsp_inv_5 == '0) && (rsp_inv_6 == '0) && (rsp_inv_7 == '0)
         && (rsp_inv_8 == '0)))
      else $error("singular beat with nonzero elements");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_inv_0) && $stable(rsp_inv_4)
         && $stable(rsp_inv_8) && $stable(rsp_singular)))
      else $error("stalled result beat changed");

endmodule

bind matrix3_inverse matrix3_inverse_checker u_checker (.*);
`default_nettype wire
